[src/fixed_timestep_accumulator_defines.svh]
// assertion macros for the fixed-timestep accumulator checker
`ifndef FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define FTA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fta_pkg.sv]
// types, codes, constants and microcode for the fixed-timestep accumulator
`default_nettype none

package fta_pkg;

  localparam logic [31:0] DEFAULT_STEP    = 32'd17476;
  localparam logic [7:0]  MAX_STEPS_LIMIT = 8'd255;
  localparam int          OUT_TIME_W      = 48;
  localparam int          ACC_W           = 48;
  localparam int          STEPQ_W         = 40;

  typedef enum logic [1:0] {
    OP_ADVANCE   = 2'd0,
    OP_CONSUME   = 2'd1,
    OP_STEP_ONCE = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_FIXED_STEP  = 2'd0,
    CFG_TIME_SCALE  = 2'd1,
    CFG_MAX_STEPS   = 2'd2,
    CFG_PAUSED_MODE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] delta;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  due_steps;
    logic        step_taken;
    logic        backlog_dropped;
    logic [15:0] alpha_frac;
    logic [47:0] sim_time;
    logic [47:0] real_time;
    logic [31:0] step_count;
  } out_req_t;

  typedef enum logic [3:0] {
    UOP_EXEC,
    UOP_MUL,
    UOP_ADD,
    UOP_OVF,
    UOP_DIV,
    UOP_DRAIN,
    UOP_AINIT,
    UOP_ASTEP,
    UOP_DONE
  } uop_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_SKIP,
    JMP_LOOP
  } jcond_t;

  typedef struct packed {
    uop_t       uop;
    jcond_t     jcond;
    logic [3:0] target;
    logic       cnt_load;
    logic [3:0] cnt_init;
  } uword_t;

  typedef struct packed {
    logic       en;
    uop_t       uop;
    logic [3:0] cnt;
  } ctrl_t;

  typedef struct packed {
    logic skip_div;
  } status_t;

  localparam logic [3:0] PC_EXEC  = 4'd0;
  localparam logic [3:0] PC_MUL   = 4'd1;
  localparam logic [3:0] PC_ADD   = 4'd2;
  localparam logic [3:0] PC_OVF   = 4'd3;
  localparam logic [3:0] PC_DIV   = 4'd4;
  localparam logic [3:0] PC_DRAIN = 4'd5;
  localparam logic [3:0] PC_AINIT = 4'd6;
  localparam logic [3:0] PC_ASTEP = 4'd7;
  localparam logic [3:0] PC_DONE  = 4'd8;

  localparam logic [3:0] DRAIN_BITS_M1 = 4'd8;
  localparam logic [3:0] ALPHA_BITS_M1 = 4'd15;

  function automatic uword_t ucode_rom(input logic [3:0] pc);
    uword_t w;
    w = '{uop: UOP_DONE, jcond: JMP_NONE, target: PC_DONE, cnt_load: 1'b0, cnt_init: 4'd0};
    case (pc)
      PC_EXEC:  w = '{UOP_EXEC,  JMP_SKIP, PC_AINIT, 1'b0, 4'd0};
      PC_MUL:   w = '{UOP_MUL,   JMP_NONE, PC_ADD,   1'b0, 4'd0};
      PC_ADD:   w = '{UOP_ADD,   JMP_NONE, PC_OVF,   1'b0, 4'd0};
      PC_OVF:   w = '{UOP_OVF,   JMP_NONE, PC_DIV,   1'b1, DRAIN_BITS_M1};
      PC_DIV:   w = '{UOP_DIV,   JMP_LOOP, PC_DIV,   1'b0, 4'd0};
      PC_DRAIN: w = '{UOP_DRAIN, JMP_NONE, PC_AINIT, 1'b0, 4'd0};
      PC_AINIT: w = '{UOP_AINIT, JMP_NONE, PC_ASTEP, 1'b1, ALPHA_BITS_M1};
      PC_ASTEP: w = '{UOP_ASTEP, JMP_LOOP, PC_ASTEP, 1'b0, 4'd0};
      PC_DONE:  w = '{UOP_DONE,  JMP_NONE, PC_DONE,  1'b0, 4'd0};
      default:  w = '{UOP_DONE,  JMP_NONE, PC_DONE,  1'b0, 4'd0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[src/fixed_timestep_accumulator.sv]
// top level of the fixed-timestep accumulator; it takes one request at a time
// an advance that accumulates runs exec, multiply, add, overflow check, a 9-step
// divide loop, drain, fraction init, a 16-step fraction loop and done; other
// requests go from exec to fraction init; each loop has its own compare-subtract
// a finished result waits in the output register while the next request is taken
// synchronous active-low reset: registers to defaults, times and counts to zero
`default_nettype none

module fixed_timestep_accumulator #(
  parameter int TIME_WIDTH = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fta_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fta_pkg::out_req_t      out_data
);

  fta_pkg::ctrl_t    ctrl;
  fta_pkg::status_t  stat;
  fta_pkg::out_req_t res;
  logic              done;
  logic              idle;
  logic              in_fire;
  logic              out_free;
  logic              out_valid_r, out_valid_nxt;
  fta_pkg::out_req_t out_data_r;

  assign in_ready  = idle;
  assign in_fire   = in_valid && idle;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fta_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .done     (done),
    .idle     (idle)
  );

  fta_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .load      (in_fire),
    .req       (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

[src/fta_sequencer.sv]
// microcode sequencer: step counter, loop counter and conditional jumps
`default_nettype none

module fta_sequencer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            out_free,
  input  wire fta_pkg::status_t stat,
  output fta_pkg::ctrl_t       ctrl,
  output logic                 done,
  output logic                 idle
);

  logic       busy_r, busy_nxt;
  logic [3:0] pc_r, pc_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  fta_pkg::uword_t uw;
  logic       stall;
  logic       jmp;

  always_comb begin
    uw    = fta_pkg::ucode_rom(pc_r);
    stall = (uw.uop == fta_pkg::UOP_DONE) && !out_free;
    jmp   = ((uw.jcond == fta_pkg::JMP_SKIP) && stat.skip_div) ||
            ((uw.jcond == fta_pkg::JMP_LOOP) && (cnt_r != 4'd0));
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    done     = 1'b0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = fta_pkg::PC_EXEC;
      end
    end else if (!stall) begin
      if (uw.uop == fta_pkg::UOP_DONE) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        pc_nxt = jmp ? uw.target : 4'(pc_r + 4'd1);
      end
      if (uw.cnt_load) begin
        cnt_nxt = uw.cnt_init;
      end else if ((uw.jcond == fta_pkg::JMP_LOOP) && (cnt_r != 4'd0)) begin
        cnt_nxt = 4'(cnt_r - 4'd1);
      end
    end
    ctrl.en  = busy_r && !stall;
    ctrl.uop = uw.uop;
    ctrl.cnt = cnt_r;
    idle     = !busy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= fta_pkg::PC_EXEC;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[src/fta_datapath.sv]
// datapath: config registers, clocks, accumulator, divide and fraction steps
`default_nettype none

module fta_datapath #(
  parameter int TIME_WIDTH = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              load,
  input  wire fta_pkg::in_req_t  req,
  input  wire fta_pkg::ctrl_t    ctrl,
  output fta_pkg::status_t       stat,
  output fta_pkg::out_req_t      res
);

  localparam int WIDE_W = (TIME_WIDTH > fta_pkg::OUT_TIME_W) ? TIME_WIDTH : fta_pkg::OUT_TIME_W;
  localparam int ACC_W  = fta_pkg::ACC_W;
  localparam int SQ_W   = fta_pkg::STEPQ_W;

  logic [31:0] fixed_step_r;
  logic [15:0] time_scale_r;
  logic [7:0]  max_steps_r;
  logic        paused_r;

  fta_pkg::op_t op_r;
  logic [31:0]  delta_r;

  logic [46:0]           prod_r, prod_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [ACC_W-1:0]      rem_r, rem_nxt;
  logic [8:0]            q_r, q_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  sat_r, sat_nxt;
  logic [15:0]           alpha_r, alpha_nxt;
  logic [7:0]            due_r, due_nxt;
  logic                  taken_r, taken_nxt;
  logic                  dropped_r, dropped_nxt;
  logic [TIME_WIDTH-1:0] sim_r, sim_nxt;
  logic [TIME_WIDTH-1:0] real_r, real_nxt;
  logic [31:0]           steps_r, steps_nxt;

  logic [31:0]      step_eff;
  logic [SQ_W-1:0]  stepq;
  logic [7:0]       lim;
  logic [7:0]       m1;
  logic [ACC_W-1:0] div_sh;
  logic [SQ_W:0]    a_try;
  logic [WIDE_W-1:0] sim_wide, real_wide;

  always_comb begin
    step_eff = (fixed_step_r == 32'd0) ? fta_pkg::DEFAULT_STEP : fixed_step_r;
    stepq    = {step_eff, 8'd0};
    m1       = (max_steps_r == 8'd0) ? 8'd1 : max_steps_r;
    lim      = (m1 > fta_pkg::MAX_STEPS_LIMIT) ? fta_pkg::MAX_STEPS_LIMIT : m1;
    div_sh   = {8'd0, stepq} << ctrl.cnt;
    a_try    = {rem_r[SQ_W-1:0], 1'b0};
    stat.skip_div = !((op_r == fta_pkg::OP_ADVANCE) && !delta_r[31] && !paused_r);
  end

  always_comb begin
    prod_nxt    = prod_r;
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    ovf_nxt     = ovf_r;
    sat_nxt     = sat_r;
    alpha_nxt   = alpha_r;
    due_nxt     = due_r;
    taken_nxt   = taken_r;
    dropped_nxt = dropped_r;
    sim_nxt     = sim_r;
    real_nxt    = real_r;
    steps_nxt   = steps_r;
    if (ctrl.en) begin
      case (ctrl.uop)
        fta_pkg::UOP_EXEC: begin
          taken_nxt   = 1'b0;
          dropped_nxt = 1'b0;
          case (op_r)
            fta_pkg::OP_ADVANCE: begin
              if (!delta_r[31]) begin
                real_nxt = real_r + TIME_WIDTH'(delta_r[30:0]);
              end
            end
            fta_pkg::OP_CONSUME: begin
              if (due_r != 8'd0) begin
                due_nxt   = due_r - 8'd1;
                sim_nxt   = sim_r + TIME_WIDTH'(step_eff);
                steps_nxt = steps_r + 32'd1;
                taken_nxt = 1'b1;
              end
            end
            fta_pkg::OP_STEP_ONCE: begin
              sim_nxt   = sim_r + TIME_WIDTH'(step_eff);
              steps_nxt = steps_r + 32'd1;
            end
            fta_pkg::OP_CLEAR: begin
              due_nxt   = 8'd0;
              acc_nxt   = '0;
              sim_nxt   = '0;
              real_nxt  = '0;
              steps_nxt = 32'd0;
            end
            default: begin
              due_nxt = due_r;
            end
          endcase
        end
        fta_pkg::UOP_MUL: begin
          prod_nxt = {16'd0, delta_r[30:0]} * {31'd0, time_scale_r};
        end
        fta_pkg::UOP_ADD: begin
          acc_nxt = acc_r + ACC_W'(prod_r);
        end
        fta_pkg::UOP_OVF: begin
          ovf_nxt = {1'b0, acc_r} >= {stepq, 9'd0};
          rem_nxt = acc_r;
          q_nxt   = 9'd0;
        end
        fta_pkg::UOP_DIV: begin
          if (rem_r >= div_sh) begin
            rem_nxt = rem_r - div_sh;
            q_nxt   = {q_r[7:0], 1'b1};
          end else begin
            q_nxt   = {q_r[7:0], 1'b0};
          end
        end
        fta_pkg::UOP_DRAIN: begin
          if (ovf_r || (q_r > {1'b0, lim})) begin
            due_nxt     = lim;
            acc_nxt     = '0;
            dropped_nxt = 1'b1;
          end else begin
            due_nxt = q_r[7:0];
            acc_nxt = rem_r;
          end
        end
        fta_pkg::UOP_AINIT: begin
          sat_nxt   = acc_r >= ACC_W'(stepq);
          rem_nxt   = acc_r;
          alpha_nxt = 16'd0;
        end
        fta_pkg::UOP_ASTEP: begin
          if (a_try >= {1'b0, stepq}) begin
            rem_nxt   = ACC_W'(a_try - {1'b0, stepq});
            alpha_nxt = {alpha_r[14:0], 1'b1};
          end else begin
            rem_nxt   = ACC_W'(a_try);
            alpha_nxt = {alpha_r[14:0], 1'b0};
          end
        end
        default: begin
          rem_nxt = rem_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_step_r <= fta_pkg::DEFAULT_STEP;
      time_scale_r <= 16'd256;
      max_steps_r  <= 8'd8;
      paused_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fta_pkg::CFG_FIXED_STEP:  fixed_step_r <= cfg_wdata;
        fta_pkg::CFG_TIME_SCALE:  time_scale_r <= cfg_wdata[15:0];
        fta_pkg::CFG_MAX_STEPS:   max_steps_r  <= cfg_wdata[7:0];
        fta_pkg::CFG_PAUSED_MODE: paused_r     <= cfg_wdata[0];
        default:                  paused_r     <= paused_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      due_r     <= 8'd0;
      sim_r     <= '0;
      real_r    <= '0;
      steps_r   <= 32'd0;
      taken_r   <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      due_r     <= due_nxt;
      sim_r     <= sim_nxt;
      real_r    <= real_nxt;
      steps_r   <= steps_nxt;
      taken_r   <= taken_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    ovf_r   <= ovf_nxt;
    sat_r   <= sat_nxt;
    alpha_r <= alpha_nxt;
    if (load) begin
      op_r    <= req.op;
      delta_r <= req.delta;
    end
  end

  always_comb begin
    sim_wide            = WIDE_W'(sim_r);
    real_wide           = WIDE_W'(real_r);
    res.due_steps       = due_r;
    res.step_taken      = taken_r;
    res.backlog_dropped = dropped_r;
    res.alpha_frac      = sat_r ? 16'hFFFF : alpha_r;
    res.sim_time        = sim_wide[fta_pkg::OUT_TIME_W-1:0];
    res.real_time       = real_wide[fta_pkg::OUT_TIME_W-1:0];
    res.step_count      = steps_r;
  end

endmodule

`default_nettype wire

[src/fta_checker.sv]
// port-level checker for the fixed-timestep accumulator, with its bind
`default_nettype none
`include "fixed_timestep_accumulator_defines.svh"

module fta_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire fta_pkg::in_req_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire fta_pkg::out_req_t out_data
);

  logic in_fire;
  logic unused_in;

  assign in_fire   = in_valid && in_ready;
  assign unused_in = ^in_data;

  `FTA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  `FTA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_fire, !in_ready, "request taken while a request is in progress")

  `FTA_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_fire, !$rose(out_valid), "result appeared one cycle after request")

  `FTA_ASSERT_NOW(a_flags_exclusive, clk, rst_n, out_valid, !(out_data.step_taken && out_data.backlog_dropped), "step taken and backlog dropped together")

endmodule

bind fixed_timestep_accumulator fta_checker u_fta_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[dv/fixed_timestep_accumulator_tb.sv]
`timescale 1ns / 1ps
// testbench for fixed_timestep_accumulator: directed and random requests checked against a predictor

module fixed_timestep_accumulator_tb;

  localparam int QUIET_CYCLES   = 40;
  localparam int MAX_MISMATCHES = 100;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  fta_pkg::cfg_idx_t cfg_index = fta_pkg::CFG_FIXED_STEP;
  logic [31:0]       cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  fta_pkg::in_req_t  in_data   = '{op: fta_pkg::OP_ADVANCE, delta: 32'sd0};
  logic              out_valid;
  logic              out_ready = 1'b0;
  fta_pkg::out_req_t out_data;

  // predictor copy of registers and state
  logic [31:0] step_r   = fta_pkg::DEFAULT_STEP;
  logic [15:0] scale_r  = 16'd256;
  logic [7:0]  max_r    = 8'd8;
  logic        paused_r = 1'b0;
  logic [47:0] acc_q    = '0;
  logic [7:0]  due_q    = '0;
  logic [47:0] sim_q    = '0;
  logic [47:0] real_q   = '0;
  logic [31:0] steps_q  = '0;

  fta_pkg::out_req_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int phase_count    = 0;
  int mismatches     = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int steps_consumed = 0;
  int backlog_drops  = 0;

  fixed_timestep_accumulator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic fta_pkg::out_req_t next_timestep_result(input fta_pkg::in_req_t req);
    fta_pkg::out_req_t r;
    logic [31:0] eff;
    logic [63:0] stepq, lim, sum, n, frac;
    eff   = (step_r == '0) ? fta_pkg::DEFAULT_STEP : step_r;
    stepq = {24'd0, eff, 8'd0};
    lim   = (max_r == '0) ? 64'd1 : {56'd0, max_r};
    r     = '0;
    case (req.op)
      fta_pkg::OP_ADVANCE: begin
        if (!req.delta[31]) begin
          real_q = real_q + {16'd0, req.delta[31:0]};
          if (!paused_r) begin
            sum = {16'd0, acc_q} + {32'd0, req.delta[31:0]} * {48'd0, scale_r};
            n   = {16'd0, sum[47:0]} / stepq;
            if (n > lim) begin
              due_q = lim[7:0];
              acc_q = '0;
              r.backlog_dropped = 1'b1;
            end else begin
              due_q = n[7:0];
              frac  = {16'd0, sum[47:0]} - n * stepq;
              acc_q = frac[47:0];
            end
          end
        end
      end
      fta_pkg::OP_CONSUME: begin
        if (due_q != '0) begin
          due_q   = due_q - 8'd1;
          sim_q   = sim_q + {16'd0, eff};
          steps_q = steps_q + 32'd1;
          r.step_taken = 1'b1;
        end
      end
      fta_pkg::OP_STEP_ONCE: begin
        sim_q   = sim_q + {16'd0, eff};
        steps_q = steps_q + 32'd1;
      end
      fta_pkg::OP_CLEAR: begin
        due_q   = '0;
        acc_q   = '0;
        sim_q   = '0;
        real_q  = '0;
        steps_q = '0;
      end
      default: ;
    endcase
    frac = {acc_q, 16'd0} / stepq;
    r.alpha_frac = (frac > 64'd65535) ? 16'hFFFF : frac[15:0];
    r.due_steps  = due_q;
    r.sim_time   = sim_q;
    r.real_time  = real_q;
    r.step_count = steps_q;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_MISMATCHES)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    fta_pkg::out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending, expected none, actual %0h",
                 $time, out_data);
      end else begin
        want = pending_results.pop_front();
        compare_field("due_steps", want.due_steps, out_data.due_steps);
        compare_field("step_taken", want.step_taken, out_data.step_taken);
        compare_field("backlog_dropped", want.backlog_dropped, out_data.backlog_dropped);
        compare_field("alpha_frac", want.alpha_frac, out_data.alpha_frac);
        compare_field("sim_time", want.sim_time, out_data.sim_time);
        compare_field("real_time", want.real_time, out_data.real_time);
        compare_field("step_count", want.step_count, out_data.step_count);
      end
    end
  end

  // result side: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  task automatic issue_request(input fta_pkg::op_t op, input logic [31:0] delta);
    fta_pkg::in_req_t  req;
    fta_pkg::out_req_t want;
    req.op    = op;
    req.delta = delta;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    want = next_timestep_result(req);
    pending_results.push_back(want);
    requests_sent++;
    if (want.step_taken) steps_consumed++;
    if (want.backlog_dropped) backlog_drops++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input fta_pkg::cfg_idx_t idx, input logic [31:0] value);
    wait_quiet();
    cfg_index <= idx;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      fta_pkg::CFG_FIXED_STEP:  step_r   = value;
      fta_pkg::CFG_TIME_SCALE:  scale_r  = value[15:0];
      fta_pkg::CFG_MAX_STEPS:   max_r    = value[7:0];
      fta_pkg::CFG_PAUSED_MODE: paused_r = value[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic random_phase(input logic [31:0] step, input logic [15:0] scale,
                              input logic [7:0] max_steps, input logic paused,
                              input int count);
    logic [63:0]  span, num;
    logic [31:0]  eff, delta;
    int unsigned  pick, k, lim;
    fta_pkg::op_t op;
    write_reg(fta_pkg::CFG_FIXED_STEP, step);
    write_reg(fta_pkg::CFG_TIME_SCALE, {16'd0, scale});
    write_reg(fta_pkg::CFG_MAX_STEPS, {24'd0, max_steps});
    write_reg(fta_pkg::CFG_PAUSED_MODE, {31'd0, paused});
    phase_count++;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) set_idling((i / 25 + phase_count) % 4);
      eff   = (step_r == '0) ? fta_pkg::DEFAULT_STEP : step_r;
      lim   = (max_r == '0) ? 1 : max_r;
      pick  = $urandom_range(99);
      delta = $urandom;
      op    = fta_pkg::OP_ADVANCE;
      if (due_q != '0 && pick < 55) begin
        op = fta_pkg::OP_CONSUME;
      end else if (pick < 75) begin
        // delta sized to make a chosen number of steps due
        k    = ($urandom_range(3) == 0) ? lim + 1 : $urandom_range(lim);
        span = {24'd0, eff, 8'd0};
        num  = span * k + (span * $urandom_range(999)) / 1000;
        if (scale_r != '0) num = num / scale_r;
        delta = (num > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : num[31:0];
      end else if (pick < 85) begin
        op = fta_pkg::OP_ADVANCE;
      end else if (pick < 93) begin
        op = fta_pkg::OP_STEP_ONCE;
      end else if (pick < 97) begin
        op = fta_pkg::OP_CONSUME;
      end else begin
        op = fta_pkg::OP_CLEAR;
      end
      issue_request(op, delta);
    end
  endtask

  task automatic test_basic_ops();
    set_idling(0);
    issue_request(fta_pkg::OP_ADVANCE, 32'd0);
    issue_request(fta_pkg::OP_ADVANCE, 32'd17476);
    issue_request(fta_pkg::OP_CONSUME, 32'd0);
    issue_request(fta_pkg::OP_CONSUME, 32'hFFFF_FFFF);
    issue_request(fta_pkg::OP_STEP_ONCE, 32'h5555_AAAA);
    issue_request(fta_pkg::OP_ADVANCE, 32'd17476 * 3 + 32'd100);
    issue_request(fta_pkg::OP_ADVANCE, 32'h8000_0000);
    issue_request(fta_pkg::OP_ADVANCE, 32'hFFFF_FFFF);
    issue_request(fta_pkg::OP_ADVANCE, 32'h7FFF_FFFF);
    issue_request(fta_pkg::OP_CONSUME, 32'd0);
    issue_request(fta_pkg::OP_CLEAR, 32'hAAAA_5555);
  endtask

  task automatic test_register_corners();
    set_idling(0);
    // zero step falls back to default, zero max acts as one
    write_reg(fta_pkg::CFG_FIXED_STEP, 32'd0);
    write_reg(fta_pkg::CFG_MAX_STEPS, 32'd0);
    write_reg(fta_pkg::CFG_TIME_SCALE, 32'hFFFF);
    issue_request(fta_pkg::OP_ADVANCE, 32'd17476);
    issue_request(fta_pkg::OP_CONSUME, 32'd0);
    write_reg(fta_pkg::CFG_PAUSED_MODE, 32'd1);
    issue_request(fta_pkg::OP_ADVANCE, 32'd1000);
    issue_request(fta_pkg::OP_CONSUME, 32'd0);
    issue_request(fta_pkg::OP_STEP_ONCE, 32'd0);
    write_reg(fta_pkg::CFG_PAUSED_MODE, 32'd0);
    write_reg(fta_pkg::CFG_TIME_SCALE, 32'd0);
    write_reg(fta_pkg::CFG_FIXED_STEP, 32'hFFFF_FFFF);
    write_reg(fta_pkg::CFG_MAX_STEPS, 32'd255);
    issue_request(fta_pkg::OP_ADVANCE, 32'h7FFF_FFFF);
    write_reg(fta_pkg::CFG_TIME_SCALE, 32'hFFFF);
    issue_request(fta_pkg::OP_ADVANCE, 32'h7FFF_FFFF);
    // shrinking the step leaves a large remainder, fraction saturates
    write_reg(fta_pkg::CFG_FIXED_STEP, 32'd1);
    issue_request(fta_pkg::OP_STEP_ONCE, 32'd0);
    issue_request(fta_pkg::OP_CLEAR, 32'd0);
    write_reg(fta_pkg::CFG_TIME_SCALE, 32'd256);
    issue_request(fta_pkg::OP_ADVANCE, 32'd255);
    issue_request(fta_pkg::OP_ADVANCE, 32'd256);
    issue_request(fta_pkg::OP_CONSUME, 32'd0);
  endtask

  task automatic test_random_traffic();
    random_phase(fta_pkg::DEFAULT_STEP, 16'd256, 8'd8, 1'b0, 100);
    random_phase(32'd1, 16'd1, 8'd255, 1'b0, 100);
    random_phase(32'hFFFF_FFFF, 16'hFFFF, 8'd1, 1'b0, 100);
    random_phase(32'd0, 16'($urandom_range(65535)), 8'd0, 1'b0, 80);
    random_phase(32'($urandom_range(1, 300000)), 16'($urandom_range(1, 65535)),
                 8'($urandom_range(1, 255)), 1'b0, 100);
  endtask

  task automatic test_paused_mode();
    logic [31:0] step;
    logic [15:0] scale;
    logic [7:0]  max_steps;
    step      = 32'($urandom_range(1, 300000));
    scale     = 16'($urandom_range(1, 65535));
    max_steps = 8'($urandom_range(1, 255));
    random_phase(step, scale, max_steps, 1'b1, 60);
    random_phase(step, scale, max_steps, 1'b0, 60);
  endtask

  task automatic test_output_backpressure();
    wait_quiet();
    set_idling(0);
    hold_cycles = 600;
    for (int i = 0; i < 24; i++)
      issue_request(fta_pkg::op_t'(2'(i % 3)), 32'($urandom_range(0, 200000)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_register_corners();
    test_random_traffic();
    test_paused_mode();
    test_output_backpressure();
    wait_quiet();
    $display("ran %0d requests and checked %0d results across %0d register writes",
             requests_sent, results_seen, reg_writes);
    $display("saw %0d consumed steps and %0d dropped backlogs; %0d mismatches",
             steps_consumed, backlog_drops, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("fixed_timestep_accumulator test passed");
    end else begin
      $display("fixed_timestep_accumulator test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("fixed_timestep_accumulator test failed");
    $finish;
  end

endmodule
